[rtl/tba_pkg.sv]
// Shared types and constants of the three-axis block averager.
// No dependencies; every other file of the block refers to this package.
package tba_pkg;

  localparam int SAMPLE_W     = 16;  // sample, offset and level width
  localparam int AVG_LOG2_DEF = 6;   // default block length, log2
  localparam int CFG_IDX_W    = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Z_OFFSET = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load_sample;  // word accepted: accumulate and count
    logic block_end;    // block complete: shift sums into averages
    logic div_start;    // load divider lanes from the sums
    logic div_step;     // one quotient bit per lane
    logic div_finish;   // sign-correct quotients into averages
    logic write_out;    // load the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_full;   // block count has reached 2^AVG_LOG2
    logic settled;      // at least one full block seen
    logic out_free;     // output register empty or being emptied
  } dp_status_t;

endpackage

[rtl/tba_if.sv]
// Valid/ready channels of the averager: sample words in, level words out.
// Depends on tba_pkg for the field width.
interface tba_sample_if;
  logic valid;
  logic ready;
  logic signed [tba_pkg::SAMPLE_W-1:0] sample_x;
  logic signed [tba_pkg::SAMPLE_W-1:0] sample_y;
  logic signed [tba_pkg::SAMPLE_W-1:0] sample_z;
  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                  output ready);
endinterface

interface tba_level_if;
  logic valid;
  logic ready;
  logic signed [tba_pkg::SAMPLE_W-1:0] level_x;
  logic signed [tba_pkg::SAMPLE_W-1:0] level_y;
  logic signed [tba_pkg::SAMPLE_W-1:0] level_z;
  logic                                settled;
  modport source (output valid, output level_x, output level_y, output level_z,
                  output settled, input ready);
  modport sink   (input valid, input level_x, input level_y, input level_z,
                  input settled, output ready);
endinterface

[rtl/tba_ctrl.sv]
// Sequencing FSM of the averager: accept, decide, divide, write out.
// Depends on tba_pkg for the command and status structs.
module tba_ctrl #(
  parameter int AVG_LOG2 = tba_pkg::AVG_LOG2_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tba_pkg::dp_status_t    status,
  output tba_pkg::ctrl_cmd_t     cmd
);

  localparam int SUM_W  = tba_pkg::SAMPLE_W + AVG_LOG2 + 1;
  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECIDE = 5'b00010,
    S_DIV    = 5'b00100,
    S_FINISH = 5'b01000,
    S_WRITE  = 5'b10000
  } state_t;

  state_t              state, state_next;
  logic [STEP_W-1:0]   step;
  logic                step_last;

  assign step_last = (step == STEP_W'(SUM_W - 1));
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_sample = 1'b1;
          state_next      = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (status.count_full) begin
          cmd.block_end = 1'b1;
          state_next    = S_WRITE;
        end else if (!status.settled) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          state_next    = S_WRITE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.div_finish = 1'b1;
        state_next     = S_WRITE;
      end
      S_WRITE: begin
        if (status.out_free) begin
          cmd.write_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV) step <= step + 1'b1;
      else                step <= '0;
    end
  end

endmodule

[rtl/tba_datapath.sv]
// Accumulators, bit-serial divider lanes, held averages, offsets and
// the output register of the averager. Depends on tba_pkg.
module tba_datapath #(
  parameter int AVG_LOG2 = tba_pkg::AVG_LOG2_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tba_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [tba_pkg::SAMPLE_W-1:0]        cfg_data,
  input  logic signed [tba_pkg::SAMPLE_W-1:0] sample_x,
  input  logic signed [tba_pkg::SAMPLE_W-1:0] sample_y,
  input  logic signed [tba_pkg::SAMPLE_W-1:0] sample_z,
  input  tba_pkg::ctrl_cmd_t                  cmd,
  output tba_pkg::dp_status_t                 status,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [tba_pkg::SAMPLE_W-1:0] level_x,
  output logic signed [tba_pkg::SAMPLE_W-1:0] level_y,
  output logic signed [tba_pkg::SAMPLE_W-1:0] level_z,
  output logic                                settled
);

  localparam int W     = tba_pkg::SAMPLE_W;
  localparam int SUM_W = W + AVG_LOG2 + 1;
  localparam int CNT_W = AVG_LOG2 + 1;

  logic signed [W-1:0]     sample [3];
  logic signed [SUM_W-1:0] sum    [3];
  logic signed [W-1:0]     avg    [3];
  logic [W-1:0]            offset [3];
  logic [W-1:0]            level  [3];
  logic [SUM_W-1:0]        quo    [3];
  logic [CNT_W-1:0]        rem    [3];
  logic                    neg    [3];
  logic [CNT_W:0]          trial  [3];
  logic [CNT_W-1:0]        count;
  logic                    done;

  assign sample[0] = sample_x;
  assign sample[1] = sample_y;
  assign sample[2] = sample_z;

  assign status.count_full = count[AVG_LOG2];
  assign status.settled    = done;
  assign status.out_free   = !out_valid || out_ready;

  // offset registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) offset[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tba_pkg::REG_X_OFFSET: offset[0] <= cfg_data;
        tba_pkg::REG_Y_OFFSET: offset[1] <= cfg_data;
        tba_pkg::REG_Z_OFFSET: offset[2] <= cfg_data;
        default: ;  // no register there
      endcase
    end
  end

  // block count and settled flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (cmd.load_sample) begin
      count <= count + 1'b1;
    end else if (cmd.block_end) begin
      count <= '0;
      done  <= 1'b1;
    end
  end

  // per-axis lanes: accumulate, then restoring division by the count
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem[i], quo[i][SUM_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        sum[i] <= '0;
        avg[i] <= '0;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (cmd.load_sample) begin
          sum[i] <= sum[i] + {{(SUM_W-W){sample[i][W-1]}}, sample[i]};
        end else if (cmd.block_end) begin
          avg[i] <= sum[i][AVG_LOG2+W-1:AVG_LOG2];  // floor shift
          sum[i] <= '0;
        end else if (cmd.div_finish) begin
          avg[i] <= neg[i] ? W'(~quo[i][W-1:0] + 1'b1) : quo[i][W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.div_start) begin
        neg[i] <= sum[i][SUM_W-1];
        quo[i] <= sum[i][SUM_W-1] ? SUM_W'(~sum[i] + 1'b1) : sum[i];
        rem[i] <= '0;
      end else if (cmd.div_step) begin
        if (trial[i] >= {1'b0, count}) begin
          rem[i] <= CNT_W'(trial[i] - {1'b0, count});
          quo[i] <= {quo[i][SUM_W-2:0], 1'b1};
        end else begin
          rem[i] <= trial[i][CNT_W-1:0];
          quo[i] <= {quo[i][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.write_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_out) begin
      for (int i = 0; i < 3; i++) level[i] <= avg[i] - offset[i];
      settled <= done;
    end
  end

  assign level_x = level[0];
  assign level_y = level[1];
  assign level_z = level[2];

endmodule

[rtl/three_axis_block_averager.sv]
// Top level of the three-axis block averager: controller plus datapath.
// Depends on tba_pkg, tba_if, tba_ctrl and tba_datapath.
//
// Each accepted sample word adds x, y and z into accumulators of
// 16 + AVG_LOG2 + 1 bits (23 at the default) and bumps the block count.
// When 2^AVG_LOG2 samples are in, the held averages become the sums
// shifted right by AVG_LOG2 (floor), the sums and count clear and
// settled goes high. Before the first full block each word updates the
// averages to the running mean, sum / count truncated toward zero.
// Every sample gives one level word: average minus offset, wrapped to
// 16 bits, plus the settled flag. Steps per word once settled: accept,
// decide, write. Before that, the running mean goes through three
// restoring divider lanes in parallel, one quotient bit per cycle, then
// a finish step sign-corrects the quotients. One word is in flight at
// a time; a finished level word sits in the output register and the
// next sample is taken while it waits. Offsets are written through
// cfg_we/cfg_idx/cfg_data (index 0 x, 1 y, 2 z, others ignored); the
// user must write them only while the block is idle (not enforced).
module three_axis_block_averager #(
  parameter int AVG_LOG2 = tba_pkg::AVG_LOG2_DEF  // 1 .. 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tba_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tba_pkg::SAMPLE_W-1:0]  cfg_data,
  tba_sample_if.sink                    samples,
  tba_level_if.source                   levels
);

  tba_pkg::ctrl_cmd_t  cmd;
  tba_pkg::dp_status_t status;

  // sequencing: one word at a time through decide / divide / write
  tba_ctrl #(
    .AVG_LOG2 (AVG_LOG2)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic, offset registers and output register
  tba_datapath #(
    .AVG_LOG2 (AVG_LOG2)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .sample_x  (samples.sample_x),
    .sample_y  (samples.sample_y),
    .sample_z  (samples.sample_z),
    .cmd       (cmd),
    .status    (status),
    .out_ready (levels.ready),
    .out_valid (levels.valid),
    .level_x   (levels.level_x),
    .level_y   (levels.level_y),
    .level_z   (levels.level_z),
    .settled   (levels.settled)
  );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for three_axis_block_averager: a directed table of sample
// words and randomised blocks, each level word checked against a local average model.
// Depends on tba_pkg, tba_if and the averager RTL.
module tb_top;

  localparam int AVG_LOG2      = tba_pkg::AVG_LOG2_DEF;
  localparam int BLOCK_LEN     = 1 << AVG_LOG2;
  // worst case per word before settling, used to size the final wait
  localparam int WORD_LATENCY  = tba_pkg::SAMPLE_W + AVG_LOG2 + 1 + 4;
  localparam int WATCHDOG_MAX  = 1000;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_WORDS   = 79;
  localparam int MIX_SPAN      = 16;   // words between redraws of the value mix

  // spare index: the block must drop writes to it
  localparam logic [tba_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef logic signed [tba_pkg::SAMPLE_W-1:0] axis_t;

  typedef struct packed {
    axis_t x;
    axis_t y;
    axis_t z;
  } triple_t;

  typedef struct packed {
    axis_t x;
    axis_t y;
    axis_t z;
    logic  settled;
  } level_word_t;

  // one row of the directed table; pinned rows carry a hand-worked level word
  typedef struct packed {
    triple_t     sample;
    logic        pinned;
    level_word_t want;
  } directed_row_t;

  // how one axis picks its values for a stretch of words
  typedef enum int {MIX_TOP, MIX_BOTTOM, MIX_NEAR_ZERO, MIX_RAIL, MIX_WIDE} axis_mix_t;

  localparam int DIRECTED_ROWS = 18;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    // first word after reset: the mean of one word is the word itself
    '{'{16'h7FFF, 16'h8000, 16'hFFFF}, 1'b1, '{16'h7FFF, 16'h8000, 16'hFFFF, 1'b0}},
    // mean of two full-scale words stays at the rails, z sums to zero
    '{'{16'h7FFF, 16'h8000, 16'h0001}, 1'b1, '{16'h7FFF, 16'h8000, 16'h0000, 1'b0}},
    // z sum -1 over 3: truncation toward zero, not floor
    '{'{16'h8000, 16'h7FFF, 16'hFFFF}, 1'b0, '0},
    '{'{16'h0000, 16'h0000, 16'hFFFE}, 1'b0, '0},
    '{'{16'h5555, 16'hAAAA, 16'h0000}, 1'b0, '0},
    '{'{16'hAAAA, 16'h5555, 16'h8000}, 1'b0, '0},
    '{'{16'hFFFF, 16'h0001, 16'h7FFF}, 1'b0, '0},
    '{'{16'h0001, 16'hFFFF, 16'h0000}, 1'b0, '0},
    '{'{16'h8000, 16'h8000, 16'h8000}, 1'b0, '0},
    '{'{16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, '0},
    '{'{16'h0000, 16'hFFFF, 16'h0001}, 1'b0, '0},
    '{'{16'h1234, 16'hEDCC, 16'h0F0F}, 1'b0, '0},
    '{'{16'hF0F0, 16'h00FF, 16'hFF00}, 1'b0, '0},
    '{'{16'h8000, 16'h8000, 16'h8000}, 1'b0, '0},
    '{'{16'h8000, 16'h8000, 16'h8000}, 1'b0, '0},
    '{'{16'h7FFF, 16'h0000, 16'h8001}, 1'b0, '0},
    '{'{16'h0002, 16'hFFFD, 16'h0003}, 1'b0, '0},
    '{'{16'hFFFC, 16'h0004, 16'hFFFB}, 1'b0, '0}
  };

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_we;
  logic [tba_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [tba_pkg::SAMPLE_W-1:0]  cfg_data;

  tba_sample_if samples_ch ();
  tba_level_if  levels_ch ();

  three_axis_block_averager #(.AVG_LOG2(AVG_LOG2)) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .samples  (samples_ch),
    .levels   (levels_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Average model: accumulators, block fill, held averages and offsets.
  // ---------------------------------------------------------------------------
  int    acc [3];
  int    fill;
  bit    block_seen;
  axis_t held [3];
  axis_t offset [3];

  level_word_t level_words [$];   // level words still owed by the block
  int          fault_count;
  bit          calm;              // phase with no idling on either side
  bit          pinned_on;         // current word has a hand-worked result
  level_word_t pinned_word;

  // Folds one sample word into the model and returns the level word it gives.
  function automatic level_word_t average_sample(triple_t s);
    axis_t       word_in [3];
    level_word_t w;
    word_in[0] = s.x;
    word_in[1] = s.y;
    word_in[2] = s.z;
    fill++;
    for (int a = 0; a < 3; a++) acc[a] += word_in[a];
    if (fill >= BLOCK_LEN) begin
      // block end: floor of sum / 2^N, then start a fresh block
      for (int a = 0; a < 3; a++) begin
        held[a] = axis_t'(acc[a] >>> AVG_LOG2);
        acc[a]  = 0;
      end
      fill       = 0;
      block_seen = 1'b1;
    end else if (!block_seen) begin
      // running mean until the first block is in; int division truncates to zero
      for (int a = 0; a < 3; a++) held[a] = axis_t'(acc[a] / fill);
    end
    // 16-bit subtraction wraps as the block does
    w.x       = held[0] - offset[0];
    w.y       = held[1] - offset[1];
    w.z       = held[2] - offset[2];
    w.settled = block_seen;
    return w;
  endfunction

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic axis_t draw_axis(axis_mix_t mix);
    case (mix)
      MIX_TOP:       return 16'h7FFF;
      MIX_BOTTOM:    return 16'h8000;
      MIX_NEAR_ZERO: return axis_t'($urandom_range(0, 6) - 3);  // small sums hit floor edges
      MIX_RAIL:      return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default:       return axis_t'($urandom);
    endcase
  endfunction

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      fault_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sample side. Data changes at the falling edge; acceptance seen at the rising.
  // ---------------------------------------------------------------------------
  task automatic push_word(triple_t s, logic pin, level_word_t want);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      samples_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples_ch.valid    <= 1'b1;
    samples_ch.sample_x <= s.x;
    samples_ch.sample_y <= s.y;
    samples_ch.sample_z <= s.z;
    pinned_on   = pin;
    pinned_word = want;
    do @(posedge clk); while (!samples_ch.ready);
  endtask

  // stop sending and wait until every owed level word has come back
  task automatic drain();
    @(negedge clk);
    samples_ch.valid <= 1'b0;
    while (level_words.size() != 0) @(posedge clk);
  endtask

  // write enable stays high across back-to-back writes; end_writes drops it
  task automatic write_offset(logic [tba_pkg::CFG_IDX_W-1:0] idx, axis_t value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      tba_pkg::REG_X_OFFSET: offset[0] = value;
      tba_pkg::REG_Y_OFFSET: offset[1] = value;
      tba_pkg::REG_Z_OFFSET: offset[2] = value;
      default: ;  // spare index: dropped
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Level side: a fresh stall drawn by draw_gap after each word taken.
  // ---------------------------------------------------------------------------
  initial begin : level_sink
    int hold;
    hold = 0;
    levels_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        levels_ch.ready <= 1'b0;
        hold--;
      end else begin
        levels_ch.ready <= 1'b1;
      end
      @(posedge clk);
      if (levels_ch.valid && levels_ch.ready) hold = draw_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard and watchdog. Sample acceptance is predicted before the level
  // word of the same edge is checked, all in one process, so no race.
  // ---------------------------------------------------------------------------
  int idle_cycles;

  always @(posedge clk) begin : score_words
    level_word_t want;
    level_word_t got;
    bit          moved;
    moved = 1'b0;
    if (!rst && samples_ch.valid && samples_ch.ready) begin
      want = average_sample(triple_t'({samples_ch.sample_x, samples_ch.sample_y,
                                       samples_ch.sample_z}));
      if (pinned_on) want = pinned_word;
      level_words.push_back(want);
      moved = 1'b1;
    end
    if (!rst && levels_ch.valid && levels_ch.ready) begin
      got = {levels_ch.level_x, levels_ch.level_y, levels_ch.level_z, levels_ch.settled};
      moved = 1'b1;
      if (level_words.size() == 0) begin
        $display("%0t: level word with none owed: expected nothing, got %h", $time, got);
        fault_count++;
      end else begin
        want = level_words.pop_front();
        check_field("level_x", want.x, got.x);
        check_field("level_y", want.y, got.y);
        check_field("level_z", want.z, got.z);
        check_field("settled", want.settled, got.settled);
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_MAX);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, then phases of random blocks, each
  // under its own offset setting written while the block is idle.
  // ---------------------------------------------------------------------------
  initial begin : run_test
    axis_mix_t mix [3];
    triple_t   s;
    axis_t     pick [3];
    int        k;

    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_idx     = tba_pkg::REG_X_OFFSET;
    cfg_data    = '0;
    samples_ch.valid    = 1'b0;
    samples_ch.sample_x = '0;
    samples_ch.sample_y = '0;
    samples_ch.sample_z = '0;
    pinned_on   = 1'b0;
    pinned_word = '0;
    calm        = 1'b0;
    fault_count = 0;
    idle_cycles = 0;
    fill        = 0;
    block_seen  = 1'b0;
    for (int a = 0; a < 3; a++) begin
      acc[a]    = 0;
      held[a]   = '0;
      offset[a] = '0;
      mix[a]    = MIX_WIDE;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed words under reset offsets of zero
    foreach (DIRECTED[i]) push_word(DIRECTED[i].sample, DIRECTED[i].pinned, DIRECTED[i].want);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      drain();
      case (phase)
        0: begin
          // spare index first: must leave every offset untouched
          write_offset(REG_NONE, 16'h1234);
          write_offset(tba_pkg::REG_X_OFFSET, 16'h7FFF);
          write_offset(tba_pkg::REG_Y_OFFSET, 16'h8000);
          write_offset(tba_pkg::REG_Z_OFFSET, 16'h0001);
        end
        1: begin
          write_offset(tba_pkg::REG_X_OFFSET, 16'h8000);
          write_offset(tba_pkg::REG_Y_OFFSET, 16'h7FFF);
          write_offset(tba_pkg::REG_Z_OFFSET, 16'hFFFF);
        end
        2: begin
          write_offset(tba_pkg::REG_X_OFFSET, 16'h0000);
          write_offset(tba_pkg::REG_Y_OFFSET, 16'h0000);
          write_offset(tba_pkg::REG_Z_OFFSET, 16'h0000);
        end
        default: begin
          // mix of full-range and small offsets, spare index now and then
          for (int a = 0; a < 3; a++)
            pick[a] = $urandom_range(0, 1) ? axis_t'($urandom)
                                           : axis_t'($urandom_range(0, 200) - 100);
          if ($urandom_range(0, 1)) write_offset(REG_NONE, axis_t'($urandom));
          write_offset(tba_pkg::REG_X_OFFSET, pick[0]);
          write_offset(tba_pkg::REG_Y_OFFSET, pick[1]);
          write_offset(tba_pkg::REG_Z_OFFSET, pick[2]);
        end
      endcase
      end_writes();

      // phase 2 runs flat out; others idle now and then unless drawn calm
      calm = (phase == 2) || ($urandom_range(0, 3) == 0);

      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % MIX_SPAN == 0) begin
          for (int a = 0; a < 3; a++) begin
            k = $urandom_range(0, 7);
            mix[a] = (k > MIX_RAIL) ? MIX_WIDE : axis_mix_t'(k);
          end
        end
        s.x = draw_axis(mix[0]);
        s.y = draw_axis(mix[1]);
        s.z = draw_axis(mix[2]);
        push_word(s, 1'b0, '0);
        // hold the sender until the block has caught up, now and then
        if ((phase == 0 && n == 30) || $urandom_range(0, 39) == 0) drain();
      end
    end

    drain();
    repeat (2 * WORD_LATENCY) @(posedge clk);
    if (level_words.size() != 0) begin
      $display("%0t: %0d level words never came: expected %h, got nothing",
               $time, level_words.size(), level_words[0]);
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[three_axis_block_averager.f]
rtl/tba_pkg.sv
rtl/tba_if.sv
rtl/tba_ctrl.sv
rtl/tba_datapath.sv
rtl/three_axis_block_averager.sv
tb/tb_top.sv
